@@ hw/rtl/md4_pkg.sv @@
// Package for the MD4 stream hasher: initial values, round constants, schedules.
// No dependencies.
package md4_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] K2   = 32'h5A827999;
  localparam logic [31:0] K3   = 32'h6ED9EBA1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
  } md4_item_t;

  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] s;
    s = i[3:0];
    case (i[5:4])
      2'd0:    msg_index = s;
      2'd1:    msg_index = {s[1:0], s[3:2]};
      default: msg_index = {s[0], s[1], s[2], s[3]};
    endcase
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] i);
    shift_amt = 5'd3;
    case (i[5:4])
      2'd0: begin
        case (i[1:0])
          2'd0: shift_amt = 5'd3;
          2'd1: shift_amt = 5'd7;
          2'd2: shift_amt = 5'd11;
          default: shift_amt = 5'd19;
        endcase
      end
      2'd1: begin
        case (i[1:0])
          2'd0: shift_amt = 5'd3;
          2'd1: shift_amt = 5'd5;
          2'd2: shift_amt = 5'd9;
          default: shift_amt = 5'd13;
        endcase
      end
      default: begin
        case (i[1:0])
          2'd0: shift_amt = 5'd3;
          2'd1: shift_amt = 5'd9;
          2'd2: shift_amt = 5'd11;
          default: shift_amt = 5'd15;
        endcase
      end
    endcase
  endfunction

endpackage

@@ hw/rtl/md4_front.sv @@
// Front queue of the MD4 hasher: holds incoming byte transactions.
// Depends on md4_pkg.
module md4_front #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  md4_pkg::md4_item_t item_in,
  output logic              avail,
  input  logic              take,
  output md4_pkg::md4_item_t item_out
);
  import md4_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  md4_item_t      mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_push;
  logic           do_take;

  assign full     = (count == (AW+1)'(DEPTH));
  assign avail    = (count != '0);
  assign do_push  = push && !full;
  assign do_take  = take && avail;
  assign item_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_take);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("front queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (!do_push && !do_take) |=> $stable(count))
    else $error("front count moved without transaction");
  assert property (@(posedge clk) disable iff (rst) full |-> avail)
    else $error("front full yet empty");
endmodule

@@ hw/rtl/md4_core.sv @@
// Back end of the MD4 hasher: block buffer, padding sequencer, 48-step round unit.
// Depends on md4_pkg.
module md4_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  output logic               take,
  input  md4_pkg::md4_item_t item,
  output logic               res_valid,
  output logic [31:0]        res_word,
  output logic [1:0]         res_index,
  input  logic               res_ready
);
  import md4_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t        state;
  logic [31:0]   wbuf [16];
  logic [31:0]   chain [4];
  logic [31:0]   v [4];
  logic [63:0]   bit_length;
  logic [63:0]   fin_len;
  logic [5:0]    pos;
  logic [5:0]    step;
  logic [1:0]    emit_idx;
  logic          finishing;
  logic          pad_first;
  logic          pad_len;
  logic          wr_en;
  logic [7:0]    wr_byte;
  logic [31:0]   w_sel;
  logic [31:0]   fx;
  logic [31:0]   kx;
  logic [31:0]   sum;
  logic [31:0]   rot;
  logic [4:0]    sh;
  logic [1:0]    t;
  logic [31:0]   xa;
  logic [31:0]   ya;
  logic [31:0]   za;
  logic [7:0]    pad_byte_sel;

  assign take      = (state == S_IDLE) && avail;
  assign res_valid = (state == S_EMIT);
  assign res_word  = chain[emit_idx];
  assign res_index = emit_idx;

  // Length bytes go only into the block that carries the length.
  always_comb begin
    pad_byte_sel = 8'h00;
    if (pad_first) begin
      pad_byte_sel = PAD_BYTE;
    end else if (pad_len && pos >= 6'd56) begin
      pad_byte_sel = fin_len[{pos[2:0], 3'b000} +: 8];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = item.data;
    if (state == S_IDLE && avail && item.has) begin
      wr_en = 1'b1;
    end else if (state == S_PAD) begin
      wr_en   = 1'b1;
      wr_byte = pad_byte_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wbuf[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  assign t  = 2'd0 - step[1:0];
  assign xa = v[t + 2'd1];
  assign ya = v[t + 2'd2];
  assign za = v[t + 2'd3];
  assign w_sel = wbuf[msg_index(step)];
  assign sh    = shift_amt(step);

  always_comb begin
    case (step[5:4])
      2'd0: begin
        fx = (xa & ya) | (~xa & za);
        kx = 32'd0;
      end
      2'd1: begin
        fx = (xa & ya) | (xa & za) | (ya & za);
        kx = K2;
      end
      default: begin
        fx = xa ^ ya ^ za;
        kx = K3;
      end
    endcase
  end

  assign sum = v[t] + fx + w_sel + kx;
  assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chain[0]   <= IV_A;
      chain[1]   <= IV_B;
      chain[2]   <= IV_C;
      chain[3]   <= IV_D;
      bit_length <= '0;
      pos        <= '0;
      step       <= '0;
      emit_idx   <= '0;
      finishing  <= 1'b0;
      pad_first  <= 1'b0;
      pad_len    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (avail) begin
            if (item.has) begin
              bit_length <= bit_length + 64'd8;
              pos        <= pos + 6'd1;
            end
            if (item.fin) begin
              fin_len   <= item.has ? bit_length + 64'd8 : bit_length;
              finishing <= 1'b1;
              pad_first <= 1'b1;
            end
            if (item.has && pos == 6'd63) begin
              state <= S_LOAD;
            end else if (item.fin) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (pad_first) begin
            pad_len <= (pos < 6'd56);
          end
          pad_first <= 1'b0;
          pos       <= pos + 6'd1;
          if (pos == 6'd63) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 4; i++) begin
            v[i] <= chain[i];
          end
          step  <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          v[t] <= rot;
          step <= step + 6'd1;
          if (step == 6'd47) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 4; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          if (!finishing) begin
            state <= S_IDLE;
          end else if (pad_first) begin
            state <= S_PAD;
          end else if (!pad_len) begin
            pad_len <= 1'b1;
            state   <= S_PAD;
          end else begin
            emit_idx <= '0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == 2'd3) begin
              chain[0]   <= IV_A;
              chain[1]   <= IV_B;
              chain[2]   <= IV_C;
              chain[3]   <= IV_D;
              bit_length <= '0;
              finishing  <= 1'b0;
              pad_len    <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && step == 6'd47) |=> state == S_ADD)
    else $error("round count slipped");
  assert property (@(posedge clk) disable iff (rst)
    take |-> state == S_IDLE)
    else $error("item taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && res_ready && emit_idx == 2'd3) |=> bit_length == '0)
    else $error("length not cleared after digest");
endmodule

@@ hw/rtl/md4_hash_stream.sv @@
// Top level of the MD4 stream hasher: front queue feeding the compression back end.
// Depends on md4_pkg, md4_front, md4_core.
//
// channel | direction | handshake        | fields
// input   | in        | push / full      | data_byte, has_byte, end_of_message
// result  | out       | pop / empty      | digest_word, word_index, last_word
//
// A full block runs through load, 48 rounds and add before the next byte is taken.
// A finish pads one byte a cycle to the block end, compresses once or twice,
// then shows four words one per pop. Synchronous reset clears control state.
// Either side may stall; the front queue keeps accepting while the core works.
module md4_hash_stream #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);
  import md4_pkg::*;

  md4_item_t in_item;
  md4_item_t q_item;
  logic      q_avail;
  logic      q_take;
  logic      res_valid;

  assign in_item = '{data: data_byte, has: has_byte, fin: end_of_message};

  md4_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item_in(in_item),
    .avail(q_avail), .take(q_take), .item_out(q_item)
  );

  md4_core u_core (
    .clk(clk), .rst(rst), .avail(q_avail), .take(q_take), .item(q_item),
    .res_valid(res_valid), .res_word(digest_word), .res_index(word_index),
    .res_ready(pop)
  );

  assign empty     = !res_valid;
  assign last_word = (word_index == 2'd3);

  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(word_index)))
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && last_word) |=> empty)
    else $error("extra result after last word");
  assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_word) |=> !empty)
    else $error("digest cut short");
endmodule
